/* hw/rtl/cia_pkg.sv */
// Shared types, constants and helpers for the connect initiator arbiter.
package cia_pkg;

  localparam int SLOTS     = 4;
  localparam int SLOT_W    = 2;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int ADDR_W    = 48;
  localparam int TYPE_W    = 8;
  localparam int MS_W      = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [MS_W-1:0] WINDOW_RESET = 16'd8000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_TYPE     = 2'd2;

  typedef enum logic [2:0] {
    ACT_SYNCED  = 3'd0,
    ACT_WANT    = 3'd1,
    ACT_STOP    = 3'd2,
    ACT_SUSPEND = 3'd3,
    ACT_RESUME  = 3'd4,
    ACT_OUTCOME = 3'd5,
    ACT_REFUSED = 3'd6,
    ACT_NONE    = 3'd7
  } action_t;

  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_CANCEL = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              set;
    logic              clr;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] addr;
    logic [TYPE_W-1:0] atype;
  } store_op_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic              many;
    logic [SLOT_W-1:0] pick;
  } scan_stat_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] addr;
    logic [TYPE_W-1:0] atype;
    logic [TYPE_W-1:0] itype;
    logic              bounded;
    logic [MS_W-1:0]   ms;
  } result_t;

  // cursor modulo the active count (cursor and count are both small)
  function automatic logic [SLOT_W-1:0] start_index(input logic [SLOT_W-1:0] cursor,
                                                    input logic [CNT_W-1:0]  n);
    logic [CNT_W-1:0] r;
    r = CNT_W'(cursor);
    for (int i = 0; i < SLOTS; i++) begin
      if (n != '0 && r >= n) begin
        r = r - n;
      end
    end
    return r[SLOT_W-1:0];
  endfunction

  // slot after idx, wrapping at the active count
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx,
                                                  input logic [CNT_W-1:0]  n);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(idx) + CNT_W'(1);
    return (inc >= n) ? '0 : inc[SLOT_W-1:0];
  endfunction

endpackage

/* hw/rtl/cia_slot_store.sv */
// Per-slot want flags and peer address table.
module cia_slot_store
  import cia_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  store_op_t         op,
  input  logic [SLOT_W-1:0] rd_slot,
  output logic [SLOTS-1:0]  wants,
  output logic [ADDR_W-1:0] rd_addr,
  output logic [TYPE_W-1:0] rd_type
);

  logic [ADDR_W-1:0] peer_addr [SLOTS];
  logic [TYPE_W-1:0] peer_type [SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      wants <= '0;
    end else if (op.set) begin
      wants[op.slot] <= 1'b1;
    end else if (op.clr) begin
      wants[op.slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.set) begin
      peer_addr[op.slot] <= op.addr;
      peer_type[op.slot] <= op.atype;
    end
  end

  assign rd_addr = peer_addr[rd_slot];
  assign rd_type = peer_type[rd_slot];

endmodule

/* hw/rtl/cia_scanner.sv */
// Round-robin search unit: visits one slot per cycle from the start slot.
module cia_scanner
  import cia_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CNT_W-1:0]  n,
  input  logic [SLOT_W-1:0] start_idx,
  input  logic [SLOTS-1:0]  wants,
  output scan_stat_t        stat
);

  logic              active;
  logic [SLOT_W-1:0] idx;
  logic [CNT_W-1:0]  left;
  logic              found;
  logic              many;
  logic [SLOT_W-1:0] pick;
  logic              hit;

  assign hit = wants[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
    end else if (active && left == CNT_W'(1)) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx   <= start_idx;
      left  <= n;
      found <= 1'b0;
      many  <= 1'b0;
      pick  <= start_idx;
    end else if (active) begin
      idx  <= next_slot(idx, n);
      left <= left - CNT_W'(1);
      if (hit) begin
        found <= 1'b1;
        many  <= many | found;
        if (!found) begin
          pick <= idx;
        end
      end
    end
  end

  // result includes the slot visited in the last cycle
  always_comb begin
    stat.done  = active && left == CNT_W'(1);
    stat.found = found | hit;
    stat.many  = many | (hit & found);
    stat.pick  = found ? pick : idx;
  end

endmodule

/* hw/rtl/connect_initiator_arbiter.sv */
// Top level: event sequencer, arbitration state and result register.
//
//   channel | handshake                | payload
//   --------+--------------------------+-----------------------------------------
//   in      | in_valid / in_stall      | action, slot, peer_address,
//           |                          | peer_address_type, connect_ok
//   out     | out_valid / out_stall    | command, target_slot, target_address,
//           |                          | target_address_type, initiator_address_type,
//           |                          | window_bounded, window_ms
//   config  | cfg_write                | cfg_index, cfg_data
//
// An event without a search goes from decode back to idle, through the emit
// state when it gives a cancel. A searching event goes from decode to the search
// state, then to emit to start an attempt or to idle if none is picked: the shared
// scan unit visits one slot per cycle. A result waits in the output register while
// the next event is taken; it is loaded only once that register is free.
// Synchronous reset clears control state; the peer table is unset.
module connect_initiator_arbiter
  import cia_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           action,
  input  logic [SLOT_W-1:0]    slot,
  input  logic [ADDR_W-1:0]    peer_address,
  input  logic [TYPE_W-1:0]    peer_address_type,
  input  logic                 connect_ok,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 command,
  output logic [SLOT_W-1:0]    target_slot,
  output logic [ADDR_W-1:0]    target_address,
  output logic [TYPE_W-1:0]    target_address_type,
  output logic [TYPE_W-1:0]    initiator_address_type,
  output logic                 window_bounded,
  output logic [MS_W-1:0]      window_ms
);

  // configuration
  logic [2:0]        slots_in_use;
  logic [MS_W-1:0]   bounded_window_ms;
  logic [TYPE_W-1:0] own_address_type;
  logic [CNT_W-1:0]  n;

  // arbitration state
  state_t            state, state_next;
  logic              pending_valid, pending_valid_next;
  logic [SLOT_W-1:0] pending_slot, pending_slot_next;
  logic              pending_forever, pending_forever_next;
  logic              scan_suspended, scan_suspended_next;
  logic              host_synced, host_synced_next;
  logic [SLOT_W-1:0] rotate_cursor, rotate_cursor_next;
  result_t           res, res_next;

  // latched event
  action_t           it_action;
  logic [SLOT_W-1:0] it_slot;
  logic [ADDR_W-1:0] it_addr;
  logic [TYPE_W-1:0] it_type;
  logic              it_ok;

  logic              in_xfer;
  logic              out_free;
  logic              owns;
  logic              slot_active;
  logic              slot_known;
  logic              go_scan;
  logic              go_emit;
  logic              scan_start;
  store_op_t         store_op;
  scan_stat_t        stat;
  logic [SLOTS-1:0]  wants;
  logic [ADDR_W-1:0] rd_addr;
  logic [TYPE_W-1:0] rd_type;

  assign n = (slots_in_use > 3'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(slots_in_use);

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use      <= '0;
      bounded_window_ms <= WINDOW_RESET;
      own_address_type  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SLOTS_IN_USE: slots_in_use      <= cfg_data[2:0];
        CFG_WINDOW_MS:    bounded_window_ms <= cfg_data[MS_W-1:0];
        CFG_OWN_TYPE:     own_address_type  <= cfg_data[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  cia_slot_store u_store (
    .clk     (clk),
    .rst     (rst),
    .op      (store_op),
    .rd_slot (stat.pick),
    .wants   (wants),
    .rd_addr (rd_addr),
    .rd_type (rd_type)
  );

  cia_scanner u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .n         (n),
    .start_idx (start_index(rotate_cursor, n)),
    .wants     (wants),
    .stat      (stat)
  );

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      it_action <= action_t'(action);
      it_slot   <= slot;
      it_addr   <= peer_address;
      it_type   <= peer_address_type;
      it_ok     <= connect_ok;
    end
  end

  assign owns        = pending_valid && pending_slot == it_slot;
  assign slot_active = CNT_W'(it_slot) < n;
  assign slot_known  = CNT_W'(it_slot) < CNT_W'(SLOTS);

  // event decode and state updates
  always_comb begin
    pending_valid_next   = pending_valid;
    pending_slot_next    = pending_slot;
    pending_forever_next = pending_forever;
    scan_suspended_next  = scan_suspended;
    host_synced_next     = host_synced;
    rotate_cursor_next   = rotate_cursor;
    res_next             = res;
    go_scan              = 1'b0;
    go_emit              = 1'b0;
    store_op             = '0;
    store_op.slot        = it_slot;
    store_op.addr        = it_addr;
    store_op.atype       = it_type;

    if (state == ST_DECODE) begin
      res_next      = '0;
      res_next.cmd  = CMD_CANCEL;
      res_next.slot = pending_slot;
      unique case (it_action)
        ACT_SYNCED: begin
          host_synced_next = 1'b1;
        end
        ACT_WANT: begin
          if (slot_active) begin
            store_op.set = 1'b1;
            if (pending_valid && !owns && pending_forever) begin
              go_emit = 1'b1;
            end else if (!owns) begin
              go_scan = 1'b1;
            end
          end
        end
        ACT_STOP: begin
          if (slot_active) begin
            store_op.clr = 1'b1;
            go_emit      = owns;
          end
        end
        ACT_SUSPEND: begin
          scan_suspended_next = 1'b1;
          go_emit             = pending_valid;
        end
        ACT_RESUME: begin
          scan_suspended_next = 1'b0;
          go_scan             = 1'b1;
        end
        ACT_OUTCOME: begin
          if (slot_known) begin
            if (owns) begin
              pending_valid_next   = 1'b0;
              pending_forever_next = 1'b0;
            end
            store_op.clr = it_ok;
            go_scan      = 1'b1;
          end
        end
        ACT_REFUSED: begin
          if (slot_known && owns) begin
            pending_valid_next   = 1'b0;
            pending_forever_next = 1'b0;
          end
        end
        default: ;
      endcase
      // search only when an attempt may start
      go_scan = go_scan && host_synced_next && !scan_suspended_next &&
                !pending_valid_next && n != '0;
    end

    if (state == ST_SCAN && stat.done && stat.found) begin
      pending_valid_next   = 1'b1;
      pending_slot_next    = stat.pick;
      pending_forever_next = !stat.many;
      rotate_cursor_next   = next_slot(stat.pick, n);
      res_next.cmd         = CMD_START;
      res_next.slot        = stat.pick;
      res_next.addr        = rd_addr;
      res_next.atype       = rd_type;
      res_next.itype       = own_address_type;
      res_next.bounded     = stat.many;
      res_next.ms          = stat.many ? bounded_window_ms : '0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (go_emit) begin
          state_next = ST_EMIT;
        end else if (go_scan) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (stat.done) begin
          state_next = stat.found ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    scan_start = 1'b0;
    unique case (state)
      ST_DECODE: scan_start = go_scan && !go_emit;
      default:   scan_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      pending_valid   <= 1'b0;
      pending_slot    <= '0;
      pending_forever <= 1'b0;
      scan_suspended  <= 1'b0;
      host_synced     <= 1'b0;
      rotate_cursor   <= '0;
    end else begin
      state           <= state_next;
      pending_valid   <= pending_valid_next;
      pending_slot    <= pending_slot_next;
      pending_forever <= pending_forever_next;
      scan_suspended  <= scan_suspended_next;
      host_synced     <= host_synced_next;
      rotate_cursor   <= rotate_cursor_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      command                <= res.cmd;
      target_slot            <= res.slot;
      target_address         <= res.addr;
      target_address_type    <= res.atype;
      initiator_address_type <= res.itype;
      window_bounded         <= res.bounded;
      window_ms              <= res.ms;
    end
  end

  a_accept_decodes : assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == ST_DECODE)
    else $error("transfer accepted but event not decoded");

  a_scan_in_state : assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == ST_SCAN)
    else $error("scan unit finished outside the search state");

  a_start_owns : assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free && res.cmd == CMD_START) |-> pending_valid)
    else $error("start command sent without a pending attempt");

  a_forever_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && command == CMD_START && !window_bounded) |-> window_ms == '0)
    else $error("forever attempt carries a window length");

endmodule
